>>> src/hmt_pkg.sv
`default_nettype none
package hmt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam int ID_W      = 8;
   localparam int PORT_W    = 16;
   localparam int BEAT_W    = 32;
   localparam int STAMP_W   = 32;
   localparam int OUTCOME_W = 3;
   localparam int TIMEOUT_W = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_REMOVE_TIMEOUT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_LIMIT       = 1'b1;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd20;
   localparam logic [ID_W-1:0]      ID_LIMIT_RST = 8'd10;

   localparam logic FUNC_UPSERT = 1'b0;
   localparam logic FUNC_SWEEP  = 1'b1;

   typedef enum logic [OUTCOME_W-1:0] {
      OC_ADDED    = 3'd0,
      OC_UPDATED  = 3'd1,
      OC_REJECTED = 3'd2,
      OC_FULL     = 3'd3,
      OC_REMOVED  = 3'd4,
      OC_DONE     = 3'd5
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [PORT_W-1:0]  port;
      logic [BEAT_W-1:0]  beat;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   typedef struct packed {
      logic        load;
      logic        rd_next;
      logic        track_free;
      logic        wr_update;
      logic        wr_add;
      logic        clr_valid;
      logic        emit;
      outcome_type outcome;
   } cmd_type;

   typedef struct packed {
      logic is_sweep;
      logic rejected;
      logic hit;
      logic scan_last;
      logic free_found;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

>>> src/hmt_req_if.sv
`default_nettype none
interface hmt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic [hmt_pkg::ID_W-1:0]    member_id;
   logic [hmt_pkg::PORT_W-1:0]  member_port;
   logic [hmt_pkg::BEAT_W-1:0]  beat_count;
   logic [hmt_pkg::STAMP_W-1:0] time_value;

   modport source (
      output valid, func, member_id, member_port, beat_count, time_value,
      input  ready
   );
   modport sink (
      input  valid, func, member_id, member_port, beat_count, time_value,
      output ready
   );
endinterface
`default_nettype wire

>>> src/hmt_rsp_if.sv
`default_nettype none
interface hmt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hmt_pkg::OUTCOME_W-1:0] outcome;
   logic [hmt_pkg::ID_W-1:0]      out_id;
   logic [hmt_pkg::PORT_W-1:0]    out_port;
   logic [hmt_pkg::BEAT_W-1:0]    out_beat;
   logic [hmt_pkg::STAMP_W-1:0]   out_time;
   logic                          last_result;

   modport source (
      output valid, outcome, out_id, out_port, out_beat, out_time, last_result,
      input  ready
   );
   modport sink (
      input  valid, outcome, out_id, out_port, out_beat, out_time, last_result,
      output ready
   );
endinterface
`default_nettype wire

>>> src/hmt_ram.sv
`default_nettype none
module hmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> src/hmt_ctrl.sv
`default_nettype none
module hmt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire hmt_pkg::sts_type sts,
   output hmt_pkg::cmd_type      cmd
);
   hmt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.outcome = hmt_pkg::OC_DONE;
      case (state_ff)
         hmt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = hmt_pkg::ST_CHECK;
            end
         end
         hmt_pkg::ST_CHECK: begin
            if (!sts.is_sweep && sts.rejected) begin
               if (sts.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.outcome = hmt_pkg::OC_REJECTED;
                  state_in    = hmt_pkg::ST_IDLE;
               end
            end else begin
               cmd.rd_next = 1'b1;
               state_in    = hmt_pkg::ST_SCAN;
            end
         end
         hmt_pkg::ST_SCAN: begin
            cmd.track_free = !sts.is_sweep;
            if (sts.hit && !sts.is_sweep) begin
               // key match ends the scan
               if (sts.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.outcome   = hmt_pkg::OC_UPDATED;
                  cmd.wr_update = 1'b1;
                  state_in      = hmt_pkg::ST_IDLE;
               end
            end else if (!sts.hit || sts.out_free) begin
               if (sts.hit) begin
                  cmd.emit      = 1'b1;
                  cmd.outcome   = hmt_pkg::OC_REMOVED;
                  cmd.clr_valid = 1'b1;
               end
               if (sts.scan_last) begin
                  state_in = hmt_pkg::ST_FINISH;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         hmt_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = hmt_pkg::ST_IDLE;
               if (sts.is_sweep) begin
                  cmd.outcome = hmt_pkg::OC_DONE;
               end else if (sts.free_found) begin
                  cmd.outcome = hmt_pkg::OC_ADDED;
                  cmd.wr_add  = 1'b1;
               end else begin
                  cmd.outcome = hmt_pkg::OC_FULL;
               end
            end
         end
         default: begin
            state_in = hmt_pkg::ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

>>> src/hmt_dp.sv
`default_nettype none
module hmt_dp #(
   parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hmt_pkg::cmd_type                   cmd,
   output hmt_pkg::sts_type                        sts,
   input  wire logic                               req_func,
   input  wire logic [hmt_pkg::ID_W-1:0]           req_member_id,
   input  wire logic [hmt_pkg::PORT_W-1:0]         req_member_port,
   input  wire logic [hmt_pkg::BEAT_W-1:0]         req_beat_count,
   input  wire logic [hmt_pkg::STAMP_W-1:0]        req_time_value,
   input  wire logic                               csr_wr_en,
   input  wire logic [hmt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [hmt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [hmt_pkg::OUTCOME_W-1:0]      rsp_outcome,
   output logic      [hmt_pkg::ID_W-1:0]           rsp_out_id,
   output logic      [hmt_pkg::PORT_W-1:0]         rsp_out_port,
   output logic      [hmt_pkg::BEAT_W-1:0]         rsp_out_beat,
   output logic      [hmt_pkg::STAMP_W-1:0]        rsp_out_time,
   output logic                                    rsp_last_result
);
   localparam int AW     = $clog2(TABLE_DEPTH);
   localparam int CW     = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W = $bits(hmt_pkg::slot_type);

   // latched word
   logic                         item_func_ff;
   logic [hmt_pkg::ID_W-1:0]     item_id_ff;
   logic [hmt_pkg::PORT_W-1:0]   item_port_ff;
   logic [hmt_pkg::BEAT_W-1:0]   item_beat_ff;
   logic [hmt_pkg::STAMP_W-1:0]  item_time_ff;

   logic [hmt_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [hmt_pkg::ID_W-1:0]      id_limit_ff;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [CW-1:0]          rd_cnt_ff;
   logic [AW-1:0]          cmp_idx_ff;
   logic                   free_found_ff;
   logic [AW-1:0]          free_idx_ff;

   logic                          rsp_valid_ff;
   logic [hmt_pkg::OUTCOME_W-1:0] rsp_outcome_ff;
   logic [hmt_pkg::ID_W-1:0]      rsp_id_ff;
   logic [hmt_pkg::PORT_W-1:0]    rsp_port_ff;
   logic [hmt_pkg::BEAT_W-1:0]    rsp_beat_ff;
   logic [hmt_pkg::STAMP_W-1:0]   rsp_time_ff;
   logic                          rsp_last_ff;

   logic [hmt_pkg::OUTCOME_W-1:0] rsp_outcome_in;
   logic [hmt_pkg::ID_W-1:0]      rsp_id_in;
   logic [hmt_pkg::PORT_W-1:0]    rsp_port_in;
   logic [hmt_pkg::BEAT_W-1:0]    rsp_beat_in;
   logic [hmt_pkg::STAMP_W-1:0]   rsp_time_in;
   logic                          rsp_last_in;

   hmt_pkg::slot_type slot_rd, slot_wr;
   logic [SLOT_W-1:0] rd_bits;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;

   logic [hmt_pkg::BEAT_W-1:0]  beat_max;
   logic [hmt_pkg::STAMP_W-1:0] time_max;
   logic [hmt_pkg::STAMP_W-1:0] age;
   logic                        expired;
   logic                        key_eq;
   logic                        cur_valid;

   hmt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (slot_wr),
      .rd_en   (cmd.rd_next),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (rd_bits)
   );

   assign slot_rd   = hmt_pkg::slot_type'(rd_bits);
   assign cur_valid = valid_ff[cmp_idx_ff];

   assign beat_max = (item_beat_ff > slot_rd.beat)  ? item_beat_ff : slot_rd.beat;
   assign time_max = (item_time_ff > slot_rd.stamp) ? item_time_ff : slot_rd.stamp;

   // negative age means a future stamp, never expires
   assign age     = item_time_ff - slot_rd.stamp;
   assign expired = !age[hmt_pkg::STAMP_W-1] &&
                    (age > {{(hmt_pkg::STAMP_W-hmt_pkg::TIMEOUT_W){1'b0}}, timeout_ff});
   assign key_eq  = (slot_rd.id == item_id_ff) && (slot_rd.port == item_port_ff);

   assign wr_en   = cmd.wr_update || cmd.wr_add;
   assign wr_addr = cmd.wr_add ? free_idx_ff : cmp_idx_ff;

   always_comb begin
      slot_wr.id   = item_id_ff;
      slot_wr.port = item_port_ff;
      if (cmd.wr_add) begin
         slot_wr.beat  = item_beat_ff;
         slot_wr.stamp = item_time_ff;
      end else begin
         slot_wr.beat  = beat_max;
         slot_wr.stamp = time_max;
      end
   end

   always_comb begin
      sts.is_sweep   = (item_func_ff == hmt_pkg::FUNC_SWEEP);
      sts.rejected   = (item_id_ff == '0) || (item_id_ff > id_limit_ff);
      sts.hit        = cur_valid && (sts.is_sweep ? expired : key_eq);
      sts.scan_last  = (rd_cnt_ff == CW'(TABLE_DEPTH));
      sts.free_found = free_found_ff;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_func_ff <= req_func;
         item_id_ff   <= req_member_id;
         item_port_ff <= req_member_port;
         item_beat_ff <= req_beat_count;
         item_time_ff <= req_time_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= hmt_pkg::TIMEOUT_RST;
         id_limit_ff <= hmt_pkg::ID_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            hmt_pkg::CSR_REMOVE_TIMEOUT: timeout_ff  <= csr_wdata;
            hmt_pkg::CSR_ID_LIMIT:       id_limit_ff <= csr_wdata[hmt_pkg::ID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         rd_cnt_ff     <= '0;
         cmp_idx_ff    <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
      end else begin
         if (cmd.load) begin
            rd_cnt_ff     <= '0;
            free_found_ff <= 1'b0;
         end
         if (cmd.rd_next) begin
            cmp_idx_ff <= rd_cnt_ff[AW-1:0];
            rd_cnt_ff  <= rd_cnt_ff + 1'b1;
         end
         // lowest empty slot seen during the upsert scan
         if (cmd.track_free && !cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmp_idx_ff;
         end
         if (cmd.clr_valid) begin
            valid_ff[cmp_idx_ff] <= 1'b0;
         end
         if (cmd.wr_add) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      rsp_outcome_in = cmd.outcome;
      rsp_id_in      = item_id_ff;
      rsp_port_in    = item_port_ff;
      rsp_beat_in    = '0;
      rsp_time_in    = '0;
      rsp_last_in    = 1'b1;
      case (cmd.outcome)
         hmt_pkg::OC_ADDED: begin
            rsp_beat_in = item_beat_ff;
            rsp_time_in = item_time_ff;
         end
         hmt_pkg::OC_UPDATED: begin
            rsp_beat_in = beat_max;
            rsp_time_in = time_max;
         end
         hmt_pkg::OC_REJECTED, hmt_pkg::OC_FULL: begin
         end
         hmt_pkg::OC_REMOVED: begin
            rsp_id_in   = slot_rd.id;
            rsp_port_in = slot_rd.port;
            rsp_beat_in = slot_rd.beat;
            rsp_time_in = slot_rd.stamp;
            rsp_last_in = 1'b0;
         end
         default: begin
            rsp_id_in   = '0;
            rsp_port_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_port_ff    <= rsp_port_in;
         rsp_beat_ff    <= rsp_beat_in;
         rsp_time_ff    <= rsp_time_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = rsp_outcome_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_port    = rsp_port_ff;
   assign rsp_out_beat    = rsp_beat_ff;
   assign rsp_out_time    = rsp_time_ff;
   assign rsp_last_result = rsp_last_ff;
endmodule
`default_nettype wire

>>> src/heartbeat_membership_table.sv
// channel   dir   word
// req       in    func, member_id, member_port, beat_count, time_value
// rsp       out   outcome, out_id, out_port, out_beat, out_time, last_result
// csr       in    csr_wr_en, csr_index, csr_wdata (write only)
//
// one word at a time: a rejected id is loaded on rsp from the check state, a key match
// at slot k ends the walk there, an add, a full table or a sweep done come after the walk
// over all slots, with one registered read per cycle unless rsp.ready holds back a result
// req.ready comes back the cycle after the last result of a word is loaded
// each result held back by rsp.ready adds its stall cycles to the walk
// reset clears the valid bits, the walk state and rsp.valid and reloads the csr defaults, no clearing pass
`default_nettype none
module heartbeat_membership_table #(
   parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   hmt_req_if.sink                              req,
   hmt_rsp_if.source                            rsp,
   input  wire logic                            csr_wr_en,
   input  wire logic [hmt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hmt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   hmt_pkg::cmd_type cmd;
   hmt_pkg::sts_type sts;
   logic             req_ready;

   hmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hmt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req.func),
      .req_member_id   (req.member_id),
      .req_member_port (req.member_port),
      .req_beat_count  (req.beat_count),
      .req_time_value  (req.time_value),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_outcome     (rsp.outcome),
      .rsp_out_id      (rsp.out_id),
      .rsp_out_port    (rsp.out_port),
      .rsp_out_beat    (rsp.out_beat),
      .rsp_out_time    (rsp.out_time),
      .rsp_last_result (rsp.last_result)
   );

   assign req.ready = req_ready;
endmodule
`default_nettype wire

>>> src/hmt_checker.sv
`default_nettype none
module hmt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [hmt_pkg::OUTCOME_W-1:0] rsp_outcome,
   input wire logic [hmt_pkg::BEAT_W-1:0]    rsp_out_beat,
   input wire logic [hmt_pkg::STAMP_W-1:0]   rsp_out_time,
   input wire logic                          rsp_last_result
);
   // a word on rsp stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped before it was taken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // only removals are followed by more words of the same sweep
   a_nonlast_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> rsp_outcome == hmt_pkg::OC_REMOVED)
      else $error("non-final word that is not a removal");

   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> !req_ready)
      else $error("new word taken in the middle of a sweep");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == hmt_pkg::OC_REJECTED ||
                    rsp_outcome == hmt_pkg::OC_FULL)
      |-> rsp_out_beat == '0 && rsp_out_time == '0)
      else $error("rejected or full word carries entry data");
endmodule

bind heartbeat_membership_table hmt_checker u_hmt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_outcome     (rsp.outcome),
   .rsp_out_beat    (rsp.out_beat),
   .rsp_out_time    (rsp.out_time),
   .rsp_last_result (rsp.last_result)
);
`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH         = hmt_pkg::TABLE_DEPTH_DEF;
   localparam int SETTLE_CYCLES = DEPTH + 4;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PRINT_LIMIT   = 100;

   localparam logic [hmt_pkg::STAMP_W-1:0] DIRECTED_START = 32'd1000;
   localparam logic [hmt_pkg::STAMP_W-1:0] DIRECTED_SWEEP = 32'd1031;
   localparam logic [hmt_pkg::PORT_W-1:0]  PORT_POOL [4]  =
      '{16'd80, 16'd8080, 16'hFFFF, 16'd1};

   typedef struct {
      logic                        func;
      logic [hmt_pkg::ID_W-1:0]    id;
      logic [hmt_pkg::PORT_W-1:0]  port;
      logic [hmt_pkg::BEAT_W-1:0]  beat;
      logic [hmt_pkg::STAMP_W-1:0] stamp;
   } member_word_type;

   typedef struct {
      hmt_pkg::outcome_type        outcome;
      logic [hmt_pkg::ID_W-1:0]    id;
      logic [hmt_pkg::PORT_W-1:0]  port;
      logic [hmt_pkg::BEAT_W-1:0]  beat;
      logic [hmt_pkg::STAMP_W-1:0] stamp;
      logic                        last;
   } outcome_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_wr_en;
   logic [hmt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hmt_pkg::CSR_DATA_W-1:0]  csr_wdata;

   hmt_req_if req_ch ();
   hmt_rsp_if rsp_ch ();

   heartbeat_membership_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // expected table contents and register values
   logic                          live      [DEPTH];
   logic [hmt_pkg::ID_W-1:0]      tbl_id    [DEPTH];
   logic [hmt_pkg::PORT_W-1:0]    tbl_port  [DEPTH];
   logic [hmt_pkg::BEAT_W-1:0]    tbl_beat  [DEPTH];
   logic [hmt_pkg::STAMP_W-1:0]   tbl_stamp [DEPTH];
   logic [hmt_pkg::TIMEOUT_W-1:0] cfg_timeout;
   logic [hmt_pkg::ID_W-1:0]      cfg_id_limit;

   member_word_type  send_queue [$];
   outcome_word_type awaited [$];
   int mismatches = 0;

   task automatic push_outcome(input hmt_pkg::outcome_type oc,
                               input logic [hmt_pkg::ID_W-1:0] id,
                               input logic [hmt_pkg::PORT_W-1:0] port,
                               input logic [hmt_pkg::BEAT_W-1:0] beat,
                               input logic [hmt_pkg::STAMP_W-1:0] stamp,
                               input logic last);
      outcome_word_type r;
      r = '{outcome: oc, id: id, port: port, beat: beat, stamp: stamp, last: last};
      awaited.insert(awaited.size(), r);
   endtask

   task automatic table_apply(input member_word_type w);
      logic [hmt_pkg::STAMP_W-1:0] age;
      int hit;
      int spare;
      hit = -1;
      spare = -1;
      if (w.func == hmt_pkg::FUNC_SWEEP) begin
         for (int i = 0; i < DEPTH; i++) begin
            age = w.stamp - tbl_stamp[i];
            // negative age means a stamp in the future, which never expires
            if (live[i] && !age[hmt_pkg::STAMP_W-1] && age > cfg_timeout) begin
               live[i] = 1'b0;
               push_outcome(hmt_pkg::OC_REMOVED, tbl_id[i], tbl_port[i], tbl_beat[i],
                            tbl_stamp[i], 1'b0);
            end
         end
         push_outcome(hmt_pkg::OC_DONE, '0, '0, '0, '0, 1'b1);
      end else if (w.id == '0 || w.id > cfg_id_limit) begin
         push_outcome(hmt_pkg::OC_REJECTED, w.id, w.port, '0, '0, 1'b1);
      end else begin
         for (int i = 0; i < DEPTH; i++) begin
            if (hit < 0 && live[i] && tbl_id[i] == w.id && tbl_port[i] == w.port) hit = i;
            if (spare < 0 && !live[i]) spare = i;
         end
         if (hit >= 0) begin
            if (w.beat > tbl_beat[hit]) tbl_beat[hit] = w.beat;
            if (w.stamp > tbl_stamp[hit]) tbl_stamp[hit] = w.stamp;
            push_outcome(hmt_pkg::OC_UPDATED, w.id, w.port, tbl_beat[hit], tbl_stamp[hit],
                         1'b1);
         end else if (spare >= 0) begin
            live[spare]      = 1'b1;
            tbl_id[spare]    = w.id;
            tbl_port[spare]  = w.port;
            tbl_beat[spare]  = w.beat;
            tbl_stamp[spare] = w.stamp;
            push_outcome(hmt_pkg::OC_ADDED, w.id, w.port, w.beat, w.stamp, 1'b1);
         end else begin
            push_outcome(hmt_pkg::OC_FULL, w.id, w.port, '0, '0, 1'b1);
         end
      end
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
   endtask

   task automatic check_word();
      outcome_word_type want;
      if (awaited.size() == 0) begin
         report("word with nothing due, outcome", rsp_ch.outcome, '0);
      end else begin
         want = awaited.pop_front();
         if (rsp_ch.outcome !== want.outcome) report("outcome", rsp_ch.outcome, want.outcome);
         if (rsp_ch.out_id !== want.id) report("out_id", rsp_ch.out_id, want.id);
         if (rsp_ch.out_port !== want.port) report("out_port", rsp_ch.out_port, want.port);
         if (rsp_ch.out_beat !== want.beat) report("out_beat", rsp_ch.out_beat, want.beat);
         if (rsp_ch.out_time !== want.stamp) report("out_time", rsp_ch.out_time, want.stamp);
         if (rsp_ch.last_result !== want.last)
            report("last_result", rsp_ch.last_result, want.last);
      end
   endtask

   // driver: bursts of words with random gaps, now and then a long run with none
   member_word_type on_bus;
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) table_apply(on_bus);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (send_queue.size() > 0) begin
               on_bus = send_queue.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.func        <= on_bus.func;
               req_ch.member_id   <= on_bus.id;
               req_ch.member_port <= on_bus.port;
               req_ch.beat_count  <= on_bus.beat;
               req_ch.time_value  <= on_bus.stamp;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = $urandom_range(20, 40);
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 8);
                     gap_left = $urandom_range(0, 6);
                  end
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: ready follows one of three stall modes in turn: none, short stalls, long stalls
   int stall_left = 0;
   int rsp_cycle = 0;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_word();
      rsp_cycle++;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         case ((rsp_cycle / 97) % 3)
            1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(0, 2);
            2: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 12);
            default: ;
         endcase
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   logic [hmt_pkg::STAMP_W-1:0] now;
   logic [hmt_pkg::BEAT_W-1:0]  beat_run;

   task automatic put_word(input logic func, input logic [hmt_pkg::ID_W-1:0] id,
                           input logic [hmt_pkg::PORT_W-1:0] port,
                           input logic [hmt_pkg::BEAT_W-1:0] beat,
                           input logic [hmt_pkg::STAMP_W-1:0] stamp);
      member_word_type w;
      w = '{func: func, id: id, port: port, beat: beat, stamp: stamp};
      send_queue.insert(send_queue.size(), w);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (send_queue.size() != 0 || req_ch.valid || awaited.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [hmt_pkg::CSR_INDEX_W-1:0] index,
                            input logic [hmt_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == hmt_pkg::CSR_REMOVE_TIMEOUT) cfg_timeout = data[hmt_pkg::TIMEOUT_W-1:0];
      else cfg_id_limit = data[hmt_pkg::ID_W-1:0];
   endtask

   task automatic random_words(input int count);
      int pick;
      int roll;
      logic [hmt_pkg::ID_W-1:0]    id;
      logic [hmt_pkg::ID_W-1:0]    top;
      logic [hmt_pkg::PORT_W-1:0]  port;
      logic [hmt_pkg::BEAT_W-1:0]  beat;
      logic [hmt_pkg::STAMP_W-1:0] stamp;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         now += $urandom_range(0, 4);
         // occasional long jump so that large timeouts still expire entries
         if ($urandom_range(0, 39) == 0) now += $urandom_range(60000, 140000);
         beat_run += $urandom_range(0, 3);
         if (pick < 14) begin
            put_word(hmt_pkg::FUNC_SWEEP, hmt_pkg::ID_W'($urandom),
                     hmt_pkg::PORT_W'($urandom), $urandom, now);
         end else if (pick < 20) begin
            put_word(1'($urandom), hmt_pkg::ID_W'($urandom), hmt_pkg::PORT_W'($urandom),
                     $urandom, $urandom);
         end else begin
            top = (cfg_id_limit > 8'd12) ? 8'd12 : cfg_id_limit;
            if (cfg_id_limit == '0) id = hmt_pkg::ID_W'($urandom_range(0, 255));
            else if ($urandom_range(0, 11) == 0) begin
               if (cfg_id_limit == 8'hFF || $urandom_range(0, 1) == 0) id = '0;
               else id = hmt_pkg::ID_W'($urandom_range(cfg_id_limit + 1, 255));
            end else if ($urandom_range(0, 4) == 0) begin
               id = hmt_pkg::ID_W'($urandom_range(1, cfg_id_limit));
            end else id = hmt_pkg::ID_W'($urandom_range(1, top));
            port = ($urandom_range(0, 4) == 0) ? hmt_pkg::PORT_W'($urandom)
                                               : PORT_POOL[$urandom_range(0, 3)];
            beat = ($urandom_range(0, 9) == 0) ? $urandom
                                               : beat_run + $urandom_range(0, 30) - 15;
            roll = $urandom_range(0, 19);
            if (roll == 0) stamp = $urandom;
            else if (roll < 3) stamp = now + $urandom_range(1, 40);
            else stamp = now - $urandom_range(0, 8);
            put_word(hmt_pkg::FUNC_UPSERT, id, port, beat, stamp);
         end
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.func        = hmt_pkg::FUNC_UPSERT;
      req_ch.member_id   = '0;
      req_ch.member_port = '0;
      req_ch.beat_count  = '0;
      req_ch.time_value  = '0;
      rsp_ch.ready       = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      cfg_timeout        = hmt_pkg::TIMEOUT_RST;
      cfg_id_limit       = hmt_pkg::ID_LIMIT_RST;
      for (int i = 0; i < DEPTH; i++) begin
         live[i]      = 1'b0;
         tbl_id[i]    = '0;
         tbl_port[i]  = '0;
         tbl_beat[i]  = '0;
         tbl_stamp[i] = '0;
      end
      now = DIRECTED_START;
      beat_run = 32'd100;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      // sweep of an empty table, then zero id, id over the limit, largest id
      put_word(hmt_pkg::FUNC_SWEEP, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, now);
      put_word(hmt_pkg::FUNC_UPSERT, 8'd0, 16'h1234, 32'd1, now);
      put_word(hmt_pkg::FUNC_UPSERT, 8'd11, 16'hFFFF, 32'hFFFF_FFFF, now);
      put_word(hmt_pkg::FUNC_UPSERT, 8'hFF, 16'd0, 32'd0, 32'd0);
      put_word(hmt_pkg::FUNC_UPSERT, 8'd10, 16'hFFFF, 32'hFFFF_FFFF, now);
      // age of exactly 2^31 reads negative and stays; one less expires
      put_word(hmt_pkg::FUNC_UPSERT, 8'd1, 16'd0, 32'd0, DIRECTED_SWEEP - 32'h8000_0000);
      put_word(hmt_pkg::FUNC_UPSERT, 8'd1, 16'd1, 32'd7,
               DIRECTED_SWEEP + 32'd1 - 32'h8000_0000);
      // updates: newer stamp with lower beat, then higher beat with older stamp
      put_word(hmt_pkg::FUNC_UPSERT, 8'd10, 16'hFFFF, 32'd5, now + 32'd10);
      put_word(hmt_pkg::FUNC_UPSERT, 8'd1, 16'd1, 32'd9, DIRECTED_SWEEP - 32'h8000_0000);
      // age equal to the timeout is kept
      put_word(hmt_pkg::FUNC_UPSERT, 8'd10, 16'd1, 32'd3, DIRECTED_SWEEP - 32'd20);
      // stamp just below wrap, age wraps positive at the sweep
      put_word(hmt_pkg::FUNC_UPSERT, 8'd2, 16'd80, 32'd1, 32'hFFFF_FFF0);
      // fill the rest of the table and go one past it
      for (int k = 0; k < 12; k++)
         put_word(hmt_pkg::FUNC_UPSERT, 8'(3 + k / 2), 16'(100 + k), 32'(k),
                  (k % 2) ? DIRECTED_SWEEP : DIRECTED_SWEEP - 32'd21);
      put_word(hmt_pkg::FUNC_SWEEP, hmt_pkg::ID_W'($urandom), hmt_pkg::PORT_W'($urandom),
               $urandom, DIRECTED_SWEEP);
      put_word(hmt_pkg::FUNC_SWEEP, hmt_pkg::ID_W'($urandom), hmt_pkg::PORT_W'($urandom),
               $urandom, DIRECTED_SWEEP);
      now = DIRECTED_SWEEP;

      wait_drained();
      write_csr(hmt_pkg::CSR_REMOVE_TIMEOUT, 16'd0);
      write_csr(hmt_pkg::CSR_ID_LIMIT, {8'($urandom), 8'hFF});
      now = 32'hFFFF_FF00;
      random_words(60);

      wait_drained();
      write_csr(hmt_pkg::CSR_REMOVE_TIMEOUT, 16'hFFFF);
      write_csr(hmt_pkg::CSR_ID_LIMIT, 16'd1);
      random_words(50);

      wait_drained();
      write_csr(hmt_pkg::CSR_ID_LIMIT, {8'($urandom), 8'd0});
      random_words(20);

      wait_drained();
      write_csr(hmt_pkg::CSR_REMOVE_TIMEOUT, hmt_pkg::TIMEOUT_RST);
      write_csr(hmt_pkg::CSR_ID_LIMIT, {8'h00, hmt_pkg::ID_LIMIT_RST});
      random_words(80);

      repeat (4) begin
         wait_drained();
         now = $urandom;
         write_csr(hmt_pkg::CSR_REMOVE_TIMEOUT, 16'($urandom_range(0, 40)));
         write_csr(hmt_pkg::CSR_ID_LIMIT, {8'($urandom), 8'($urandom_range(1, 20))});
         random_words(60);
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/hmt_pkg.sv
src/hmt_req_if.sv
src/hmt_rsp_if.sv
src/hmt_ram.sv
src/hmt_ctrl.sv
src/hmt_dp.sv
src/heartbeat_membership_table.sv
src/hmt_checker.sv
verif/tb_top.sv
